// ===== rtl/hlmdu_pkg.sv =====
// ----------------------------------------------------------------------------
// hlmdu_pkg
// Shared types and constants for the HI/LO multiply-divide unit.
// ----------------------------------------------------------------------------
package hlmdu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned CntW  = $clog2(DivSteps);

  typedef enum logic [OpW-1:0] {
    OP_MULT  = 3'd0,
    OP_MULTU = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MFHI  = 3'd4,
    OP_MFLO  = 3'd5,
    OP_MTHI  = 3'd6,
    OP_MTLO  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_DIV  = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic commit;
  } cmd_t;

endpackage

// ===== rtl/hi_lo_multiply_divide_unit.sv =====
// ----------------------------------------------------------------------------
// hi_lo_multiply_divide_unit
// HI/LO multiply-divide unit: one HI/LO-class instruction per input word.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. Moves to and from HI/LO go
// from accept straight to commit, MULT/MULTU add one registered 33x33
// multiply, and DIV/DIVU run a load step, 32 iterations of the radix-2
// restoring divider and a sign-fix/commit step. The result word sits in
// an output register, so a finished word may wait for out_tready
// while the next instruction is already accepted and computed; the commit of
// that next word waits until the output register is free. A zero divisor
// writes the dividend to HI, all ones to LO and sets the flag in out_tuser.
module hi_lo_multiply_divide_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // rs_value[31:0], rt_value[63:32]
  input  logic [2:0]   in_tuser,   // op[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // read_value[31:0], hi_now[63:32], lo_now[95:64]
  output logic [0:0]   out_tuser   // divide_by_zero[0]
);

  hlmdu_pkg::cmd_t cmd;
  hlmdu_pkg::op_t  in_op;
  logic            out_dz;

  assign in_op = hlmdu_pkg::op_t'(in_tuser);

  hlmdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_op),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  hlmdu_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_op   (in_op),
    .in_rs   (in_tdata[31:0]),
    .in_rt   (in_tdata[63:32]),
    .out_data(out_tdata),
    .out_dz  (out_dz)
  );

  assign out_tuser = out_dz;

endmodule

// ===== rtl/hlmdu_dp.sv =====
// ----------------------------------------------------------------------------
// hlmdu_dp
// Datapath: operand capture, registered multiplier, radix-2 restoring divider,
// HI/LO registers and the result word register.
// ----------------------------------------------------------------------------
module hlmdu_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hlmdu_pkg::cmd_t            cmd,
  input  hlmdu_pkg::op_t             in_op,
  input  logic [hlmdu_pkg::WordW-1:0] in_rs,
  input  logic [hlmdu_pkg::WordW-1:0] in_rt,
  output logic [3*hlmdu_pkg::WordW-1:0] out_data,
  output logic                       out_dz
);

  localparam int unsigned W = hlmdu_pkg::WordW;

  hlmdu_pkg::op_t op_r;
  logic [W-1:0]   a_r;
  logic [W-1:0]   mb_r;
  logic           b_zero_r;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [2*W-1:0] prod_r;
  logic [W-1:0]   hi_r, hi_nxt;
  logic [W-1:0]   lo_r, lo_nxt;
  logic [W-1:0]   rd_nxt;
  logic           dz_nxt;
  logic [3*W-1:0] out_data_r;
  logic           out_dz_r;

  logic                  sgn_mul;
  logic signed [W:0]     mul_a, mul_b;
  logic signed [2*W+1:0] prod_full;
  logic [W:0]            shifted;
  logic [W+1:0]          diff;
  logic                  neg_q, neg_r;

  assign sgn_mul   = (op_r == hlmdu_pkg::OP_MULT);
  assign mul_a     = $signed({sgn_mul & a_r[W-1], a_r});
  assign mul_b     = $signed({sgn_mul & mb_r[W-1], mb_r});
  assign prod_full = mul_a * mul_b;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, mb_r};

  always_comb begin
    if (!diff[W+1]) begin
      rem_nxt = diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  // signed divide keeps the raw divisor sign in b_neg_r
  logic b_neg_r;
  assign neg_q = (op_r == hlmdu_pkg::OP_DIV) & (a_r[W-1] ^ b_neg_r);
  assign neg_r = (op_r == hlmdu_pkg::OP_DIV) & a_r[W-1];

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    rd_nxt = '0;
    dz_nxt = 1'b0;
    unique case (op_r)
      hlmdu_pkg::OP_MULT, hlmdu_pkg::OP_MULTU: begin
        hi_nxt = prod_r[2*W-1:W];
        lo_nxt = prod_r[W-1:0];
      end
      hlmdu_pkg::OP_DIV, hlmdu_pkg::OP_DIVU: begin
        if (b_zero_r) begin
          hi_nxt = a_r;
          lo_nxt = '1;
          dz_nxt = 1'b1;
        end else begin
          hi_nxt = neg_r ? (W'(0) - rem_r) : rem_r;
          lo_nxt = neg_q ? (W'(0) - quo_r) : quo_r;
        end
      end
      hlmdu_pkg::OP_MFHI: rd_nxt = hi_r;
      hlmdu_pkg::OP_MFLO: rd_nxt = lo_r;
      hlmdu_pkg::OP_MTHI: hi_nxt = a_r;
      hlmdu_pkg::OP_MTLO: lo_nxt = a_r;
      default: begin
        hi_nxt = hi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      a_r      <= in_rs;
      b_zero_r <= (in_rt == '0);
      b_neg_r  <= in_rt[W-1];
      rem_r    <= '0;
      if (in_op == hlmdu_pkg::OP_DIV && in_rs[W-1]) begin
        quo_r <= W'(0) - in_rs;
      end else begin
        quo_r <= in_rs;
      end
      if (in_op == hlmdu_pkg::OP_DIV && in_rt[W-1]) begin
        mb_r <= W'(0) - in_rt;
      end else begin
        mb_r <= in_rt;
      end
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.mul) begin
      prod_r <= prod_full[2*W-1:0];
    end
    if (cmd.commit) begin
      out_data_r <= {lo_nxt, hi_nxt, rd_nxt};
      out_dz_r   <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
    end else if (cmd.commit) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign out_data = out_data_r;
  assign out_dz   = out_dz_r;

endmodule

// ===== rtl/hlmdu_ctrl.sv =====
// ----------------------------------------------------------------------------
// hlmdu_ctrl
// Controller: sequences operand load, multiply, divide iterations and the
// commit into the result word register; owns both handshakes.
// ----------------------------------------------------------------------------
module hlmdu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  hlmdu_pkg::op_t  in_op,
  output logic            out_tvalid,
  input  logic            out_tready,
  output hlmdu_pkg::cmd_t cmd
);

  localparam int unsigned CW = hlmdu_pkg::CntW;
  localparam logic [CW-1:0] LastStep = CW'(hlmdu_pkg::DivSteps - 1);

  hlmdu_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hlmdu_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      hlmdu_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          unique case (in_op)
            hlmdu_pkg::OP_MULT, hlmdu_pkg::OP_MULTU: state_nxt = hlmdu_pkg::S_MUL;
            hlmdu_pkg::OP_DIV, hlmdu_pkg::OP_DIVU:   state_nxt = hlmdu_pkg::S_DIV;
            default:                                 state_nxt = hlmdu_pkg::S_DONE;
          endcase
        end
      end
      hlmdu_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = hlmdu_pkg::S_DONE;
      end
      hlmdu_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == LastStep) begin
          state_nxt = hlmdu_pkg::S_DONE;
        end
      end
      hlmdu_pkg::S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = hlmdu_pkg::S_IDLE;
        end
      end
      default: state_nxt = hlmdu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed word not presented");

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("commit overwrites a pending word");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_op == hlmdu_pkg::OP_DIV || in_op == hlmdu_pkg::OP_DIVU))
      |=> (state_r == hlmdu_pkg::S_DIV && cnt_r == '0))
    else $error("divide did not start at step zero");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hlmdu_pkg::S_DIV && cnt_r == LastStep) |=> state_r == hlmdu_pkg::S_DONE)
    else $error("divide did not finish after last step");

endmodule
